// ----- sv/brute_force_word_enumerator_defines.svh -----
// assertion macros used by the word stage (bfwe_word) of the word enumerator rtl
// expects signals named clk and arst_n in the including module
`ifndef BRUTE_FORCE_WORD_ENUMERATOR_DEFINES_SVH
`define BRUTE_FORCE_WORD_ENUMERATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BFWE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bfwe assertion failed");

// next-cycle implication, checked out of reset
`define BFWE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bfwe assertion failed");

`endif

// ----- sv/bfwe_pkg.sv -----
// shared types and constants for the brute force word enumerator
// no dependencies
package bfwe_pkg;

	localparam int MAX_LEN_DEF        = 8;
	localparam int ALPHABET_DEPTH_DEF = 64;
	localparam int COUNT_W            = 49;
	localparam int WORD_W             = 64;
	localparam int LEN_W              = 4;
	localparam int SIZE_W             = 7;
	localparam int IDX_W              = 6;
	localparam int CHAR_W             = 8;

	localparam logic [LEN_W-1:0]  MAX_WORD_LENGTH_RST = 4'd5;
	localparam logic [SIZE_W-1:0] ALPHABET_SIZE_RST   = 7'd62;
	localparam logic [WORD_W-1:0] SECRET_WORD_RST     = 64'd0;
	localparam logic [LEN_W-1:0]  SECRET_LENGTH_RST   = 4'd5;

	typedef enum logic [1:0] {
		REG_MAX_WORD_LENGTH = 2'd0,
		REG_ALPHABET_SIZE   = 2'd1,
		REG_SECRET_WORD     = 2'd2,
		REG_SECRET_LENGTH   = 2'd3
	} cfg_reg_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// outcome of one step as decided by the position sequencer
	typedef struct packed {
		logic             ok;
		logic [LEN_W-1:0] len;
	} step_res_t;

endpackage

// ----- sv/bfwe_table.sv -----
// alphabet memory: one write port, one registered read port
// depends on bfwe_pkg
module bfwe_table #(
	parameter int ALPHABET_DEPTH = bfwe_pkg::ALPHABET_DEPTH_DEF,
	parameter int AW             = $clog2(ALPHABET_DEPTH)
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [bfwe_pkg::CHAR_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [bfwe_pkg::CHAR_W-1:0] rd_data_s2
);
	import bfwe_pkg::*;

	logic [CHAR_W-1:0] mem [ALPHABET_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s2 <= mem[rd_addr];
		end
	end

endmodule

// ----- sv/bfwe_seq.sv -----
// position sequencer: keeps the place indices and decides the next word
// depends on bfwe_pkg; drives the alphabet read address
module bfwe_seq #(
	parameter int MAX_LEN        = bfwe_pkg::MAX_LEN_DEF,
	parameter int ALPHABET_DEPTH = bfwe_pkg::ALPHABET_DEPTH_DEF,
	parameter int AW             = $clog2(ALPHABET_DEPTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step_en,
	input  logic [bfwe_pkg::LEN_W-1:0]   max_word_length,
	input  logic [bfwe_pkg::SIZE_W-1:0]  alphabet_size,
	output logic [AW-1:0]                rd_addr,
	output bfwe_pkg::step_res_t          info_s2,
	output logic [AW-1:0]                addr_s2
);
	import bfwe_pkg::*;

	localparam int PW = AW + 1;
	localparam int CW = (PW > SIZE_W) ? PW : SIZE_W;

	logic [AW-1:0]    pos_q [MAX_LEN];
	logic [LEN_W-1:0] len_q;
	logic             started_q;
	logic             exh_q;

	logic [LEN_W-1:0] maxlen;
	logic [PW-1:0]    size;
	logic [PW-1:0]    pinc [MAX_LEN];
	logic             hit;
	logic [LEN_W-1:0] hit_place;
	logic [PW-1:0]    hit_val;

	logic             nxt_ok;
	logic [LEN_W-1:0] nxt_len;
	logic             nxt_started;
	logic             nxt_exh;
	logic             upd;
	logic [LEN_W-1:0] place;
	logic [AW-1:0]    new_pos;

	always_comb begin
		if (max_word_length == '0) begin
			maxlen = LEN_W'(1);
		end else if (max_word_length > LEN_W'(MAX_LEN)) begin
			maxlen = LEN_W'(MAX_LEN);
		end else begin
			maxlen = max_word_length;
		end
		if (CW'(alphabet_size) > CW'(ALPHABET_DEPTH)) begin
			size = PW'(ALPHABET_DEPTH);
		end else begin
			size = PW'(alphabet_size);
		end
	end

	// carry target: deepest place inside the length limit that can still count up
	always_comb begin
		hit       = 1'b0;
		hit_place = '0;
		hit_val   = '0;
		for (int k = 0; k < MAX_LEN; k++) begin
			pinc[k] = {1'b0, pos_q[k]} + PW'(1);
			if (LEN_W'(k) < maxlen && pinc[k] < size) begin
				hit       = 1'b1;
				hit_place = LEN_W'(k);
				hit_val   = pinc[k];
			end
		end
	end

	always_comb begin
		nxt_ok      = 1'b0;
		nxt_len     = len_q;
		nxt_started = started_q;
		nxt_exh     = exh_q;
		upd         = 1'b0;
		place       = '0;
		new_pos     = '0;
		if (exh_q) begin
			nxt_ok = 1'b0;
		end else if (!started_q) begin
			nxt_started = 1'b1;
			if (size != '0) begin
				nxt_ok  = 1'b1;
				nxt_len = LEN_W'(1);
				upd     = 1'b1;
			end else begin
				nxt_exh = 1'b1;
			end
		end else if (size == '0 || len_q == '0) begin
			nxt_exh = 1'b1;
		end else if (len_q < maxlen) begin
			// extend by one place at the first letter
			nxt_ok  = 1'b1;
			nxt_len = len_q + LEN_W'(1);
			place   = len_q;
			upd     = 1'b1;
		end else if (hit) begin
			nxt_ok  = 1'b1;
			nxt_len = hit_place + LEN_W'(1);
			place   = hit_place;
			new_pos = AW'(hit_val);
			upd     = 1'b1;
		end else begin
			nxt_len = '0;
			nxt_exh = 1'b1;
		end
	end

	assign rd_addr = new_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_LEN; k++) begin
				pos_q[k] <= '0;
			end
			len_q     <= '0;
			started_q <= 1'b0;
			exh_q     <= 1'b0;
		end else if (step_en) begin
			for (int k = 0; k < MAX_LEN; k++) begin
				if (upd && LEN_W'(k) == place) begin
					pos_q[k] <= new_pos;
				end
			end
			len_q     <= nxt_len;
			started_q <= nxt_started;
			exh_q     <= nxt_exh;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			info_s2.ok  <= nxt_ok;
			info_s2.len <= nxt_len;
			addr_s2     <= new_pos;
		end
	end

endmodule

// ----- sv/bfwe_word.sv -----
// word stage: keeps the current word bytes, patches reloaded letters,
// compares against the secret and holds the result register; depends on bfwe_pkg
`include "brute_force_word_enumerator_defines.svh"
module bfwe_word #(
	parameter int MAX_LEN        = bfwe_pkg::MAX_LEN_DEF,
	parameter int ALPHABET_DEPTH = bfwe_pkg::ALPHABET_DEPTH_DEF,
	parameter int AW             = $clog2(ALPHABET_DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s2_move,
	input  logic                          s2_load,
	input  logic                          ld_ok_s2,
	input  logic [AW-1:0]                 ld_idx_s2,
	input  logic [bfwe_pkg::CHAR_W-1:0]   ld_char_s2,
	input  bfwe_pkg::step_res_t           info_s2,
	input  logic [AW-1:0]                 addr_s2,
	input  logic [bfwe_pkg::CHAR_W-1:0]   rd_data_s2,
	input  logic [bfwe_pkg::WORD_W-1:0]   secret_word,
	input  logic [bfwe_pkg::LEN_W-1:0]    secret_length,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [bfwe_pkg::WORD_W-1:0]   word,
	output logic [bfwe_pkg::LEN_W-1:0]    word_length,
	output logic                          match,
	output logic                          done_res,
	output logic [bfwe_pkg::COUNT_W-1:0]  word_count
);
	import bfwe_pkg::*;

	localparam int NB = WORD_W / CHAR_W;

	logic [MAX_LEN-1:0][CHAR_W-1:0] word_q;
	logic [AW-1:0]                  wpos_q [MAX_LEN];
	logic [LEN_W-1:0]               wlen_q;
	logic                           found_q;
	logic [COUNT_W-1:0]             count_q;

	logic                           res_valid_q;
	logic [WORD_W-1:0]              res_word_q;
	logic [LEN_W-1:0]               res_len_q;
	logic                           res_match_q;
	logic                           res_done_q;
	logic [COUNT_W-1:0]             res_count_q;

	logic                           adv;
	logic                           emit;
	logic [LEN_W-1:0]               place;
	logic [MAX_LEN-1:0][CHAR_W-1:0] word_nxt;
	logic [WORD_W-1:0]              word_flat;
	logic [WORD_W-1:0]              secret_mask;
	logic                           hit;
	logic [COUNT_W-1:0]             count_nxt;

	assign adv       = !res_valid_q || res_ready;
	assign emit      = s2_move && !s2_load;
	assign place     = info_s2.len - LEN_W'(1);
	assign count_nxt = count_q + COUNT_W'(1);

	// keep the prefix below the changed place, drop everything above it
	always_comb begin
		for (int k = 0; k < MAX_LEN; k++) begin
			if (LEN_W'(k) < place) begin
				word_nxt[k] = word_q[k];
			end else if (LEN_W'(k) == place) begin
				word_nxt[k] = rd_data_s2;
			end else begin
				word_nxt[k] = '0;
			end
		end
		word_flat = WORD_W'(word_nxt);
		for (int b = 0; b < NB; b++) begin
			secret_mask[b*CHAR_W +: CHAR_W] =
				(LEN_W'(b) < secret_length) ? {CHAR_W{1'b1}} : {CHAR_W{1'b0}};
		end
		hit = (secret_length != '0) && (secret_length <= LEN_W'(NB)) &&
			(secret_length == info_s2.len) &&
			(word_flat == (secret_word & secret_mask));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q      <= '0;
			found_q     <= 1'b0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit && !found_q && info_s2.ok) begin
				wlen_q  <= info_s2.len;
				count_q <= count_nxt;
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			if (adv) begin
				res_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move && s2_load && ld_ok_s2) begin
			// a reloaded letter shows up in every place of the live word that uses it
			for (int k = 0; k < MAX_LEN; k++) begin
				if (LEN_W'(k) < wlen_q && wpos_q[k] == ld_idx_s2) begin
					word_q[k] <= ld_char_s2;
				end
			end
		end else if (emit && !found_q && info_s2.ok) begin
			word_q <= word_nxt;
			for (int k = 0; k < MAX_LEN; k++) begin
				if (LEN_W'(k) == place) begin
					wpos_q[k] <= addr_s2;
				end
			end
		end
		if (emit) begin
			if (found_q || !info_s2.ok) begin
				res_word_q  <= '0;
				res_len_q   <= '0;
				res_match_q <= 1'b0;
				res_done_q  <= 1'b1;
				res_count_q <= count_q;
			end else begin
				res_word_q  <= word_flat;
				res_len_q   <= info_s2.len;
				res_match_q <= hit;
				res_done_q  <= 1'b0;
				res_count_q <= count_nxt;
			end
		end
	end

	assign res_valid   = res_valid_q;
	assign word        = res_word_q;
	assign word_length = res_len_q;
	assign match       = res_match_q;
	assign done_res    = res_done_q;
	assign word_count  = res_count_q;

	`BFWE_ASSERT_NEXT(a_found_sticky, found_q, found_q)
	`BFWE_ASSERT_IMP(a_done_empty, res_valid_q && res_done_q,
		res_len_q == '0 && !res_match_q && res_word_q == '0)
	`BFWE_ASSERT_NEXT(a_count_step, emit && !found_q && info_s2.ok,
		count_q == $past(count_q) + COUNT_W'(1))

endmodule

// ----- sv/brute_force_word_enumerator.sv -----
// channel   | handshake               | carries
// ----------+-------------------------+----------------------------------------------
// item      | item_valid / item_ready | op, entry_index, entry_char
// result    | res_valid / res_ready   | word, word_length, match, done_res, word_count
// config    | cfg_we (no wait)        | cfg_index, cfg_data
// one request per cycle on the item channel while item_ready is high;
// a step result passes the registered alphabet read stage, then the result register
// a load request passes the read stage without waiting for the result register and gives no result
// result register and read stage together absorb a stalled result side
// arst_n clears positions, flags and count; the alphabet is unknown until loaded
// top level of the brute force word enumerator
// depends on bfwe_pkg, bfwe_seq, bfwe_table, bfwe_word
module brute_force_word_enumerator #(
	parameter int MAX_LEN        = bfwe_pkg::MAX_LEN_DEF,
	parameter int ALPHABET_DEPTH = bfwe_pkg::ALPHABET_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  bfwe_pkg::cfg_reg_t            cfg_index,
	input  logic [bfwe_pkg::WORD_W-1:0]   cfg_data,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic                          op,
	input  logic [bfwe_pkg::IDX_W-1:0]    entry_index,
	input  logic [bfwe_pkg::CHAR_W-1:0]   entry_char,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [bfwe_pkg::WORD_W-1:0]   word,
	output logic [bfwe_pkg::LEN_W-1:0]    word_length,
	output logic                          match,
	output logic                          done_res,
	output logic [bfwe_pkg::COUNT_W-1:0]  word_count
);
	import bfwe_pkg::*;

	localparam int AW = $clog2(ALPHABET_DEPTH);
	localparam int IW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;

	logic [LEN_W-1:0]  max_word_length_q;
	logic [SIZE_W-1:0] alphabet_size_q;
	logic [WORD_W-1:0] secret_word_q;
	logic [LEN_W-1:0]  secret_length_q;

	logic              s2_valid_q;
	logic              s2_load_s2;
	logic              ld_ok_s2;
	logic [AW-1:0]     ld_idx_s2;
	logic [CHAR_W-1:0] ld_char_s2;

	logic              accept;
	logic              step_en;
	logic              ld_in_range;
	logic              s2_move;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     addr_s2;
	logic [CHAR_W-1:0] rd_data_s2;
	step_res_t         info_s2;

	assign ld_in_range = IW'(entry_index) < IW'(ALPHABET_DEPTH);
	// a load leaves the read stage at once, a step waits for room in the result register
	assign s2_move     = s2_valid_q && (s2_load_s2 || !res_valid || res_ready);
	assign item_ready  = !s2_valid_q || s2_move;
	assign accept      = item_valid && item_ready;
	assign step_en     = accept && (op == OP_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_word_length_q <= MAX_WORD_LENGTH_RST;
			alphabet_size_q   <= ALPHABET_SIZE_RST;
			secret_word_q     <= SECRET_WORD_RST;
			secret_length_q   <= SECRET_LENGTH_RST;
			s2_valid_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_WORD_LENGTH: max_word_length_q <= cfg_data[LEN_W-1:0];
					REG_ALPHABET_SIZE:   alphabet_size_q   <= cfg_data[SIZE_W-1:0];
					REG_SECRET_WORD:     secret_word_q     <= cfg_data;
					REG_SECRET_LENGTH:   secret_length_q   <= cfg_data[LEN_W-1:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				s2_valid_q <= 1'b1;
			end else if (s2_move) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s2_load_s2 <= (op == OP_LOAD);
			ld_ok_s2   <= ld_in_range;
			ld_idx_s2  <= AW'(entry_index);
			ld_char_s2 <= entry_char;
		end
	end

	bfwe_seq #(
		.MAX_LEN        (MAX_LEN),
		.ALPHABET_DEPTH (ALPHABET_DEPTH),
		.AW             (AW)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.step_en         (step_en),
		.max_word_length (max_word_length_q),
		.alphabet_size   (alphabet_size_q),
		.rd_addr         (rd_addr),
		.info_s2         (info_s2),
		.addr_s2         (addr_s2)
	);

	bfwe_table #(
		.ALPHABET_DEPTH (ALPHABET_DEPTH),
		.AW             (AW)
	) u_table (
		.clk        (clk),
		.wr_en      (accept && (op == OP_LOAD) && ld_in_range),
		.wr_addr    (AW'(entry_index)),
		.wr_data    (entry_char),
		.rd_en      (step_en),
		.rd_addr    (rd_addr),
		.rd_data_s2 (rd_data_s2)
	);

	bfwe_word #(
		.MAX_LEN        (MAX_LEN),
		.ALPHABET_DEPTH (ALPHABET_DEPTH),
		.AW             (AW)
	) u_word (
		.clk           (clk),
		.arst_n        (arst_n),
		.s2_move       (s2_move),
		.s2_load       (s2_load_s2),
		.ld_ok_s2      (ld_ok_s2),
		.ld_idx_s2     (ld_idx_s2),
		.ld_char_s2    (ld_char_s2),
		.info_s2       (info_s2),
		.addr_s2       (addr_s2),
		.rd_data_s2    (rd_data_s2),
		.secret_word   (secret_word_q),
		.secret_length (secret_length_q),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.word          (word),
		.word_length   (word_length),
		.match         (match),
		.done_res      (done_res),
		.word_count    (word_count)
	);

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for brute_force_word_enumerator
// depends on bfwe_pkg and the enumerator rtl; a class tracks the expected word sequence
module tb_top;
	import bfwe_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int RANDOM_ITEMS   = 430;
	localparam int QUIET_FROM     = 360;

	typedef struct packed {
		logic [WORD_W-1:0]  word;
		logic [LEN_W-1:0]   len;
		logic               is_match;
		logic               done;
		logic [COUNT_W-1:0] count;
	} word_res_t;

	class word_board;
		logic [CHAR_W-1:0]  letters [ALPHABET_DEPTH_DEF];
		int unsigned        pos [MAX_LEN_DEF];
		int unsigned        cur_len;
		bit                 started;
		bit                 found;
		bit                 exhausted;
		logic [COUNT_W-1:0] count;
		logic [LEN_W-1:0]   max_len_reg;
		logic [SIZE_W-1:0]  size_reg;
		logic [WORD_W-1:0]  secret_reg;
		logic [LEN_W-1:0]   secret_len_reg;
		word_res_t          words_due [$];
		int                 errors;

		function new();
			foreach (letters[i]) letters[i] = '0;
			foreach (pos[i]) pos[i] = 0;
			cur_len        = 0;
			started        = 1'b0;
			found          = 1'b0;
			exhausted      = 1'b0;
			count          = '0;
			max_len_reg    = MAX_WORD_LENGTH_RST;
			size_reg       = ALPHABET_SIZE_RST;
			secret_reg     = SECRET_WORD_RST;
			secret_len_reg = SECRET_LENGTH_RST;
			errors         = 0;
		endfunction

		function void set_reg(cfg_reg_t r, logic [WORD_W-1:0] d);
			case (r)
				REG_MAX_WORD_LENGTH: max_len_reg = d[LEN_W-1:0];
				REG_ALPHABET_SIZE: size_reg = d[SIZE_W-1:0];
				REG_SECRET_WORD: secret_reg = d;
				REG_SECRET_LENGTH: secret_len_reg = d[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		// depth-first successor of the current prefix, 0 when every place carried out
		function bit next_prefix(int unsigned size, int unsigned lim);
			if (cur_len < lim) begin
				pos[cur_len] = 0;
				cur_len++;
				return 1'b1;
			end
			cur_len = lim;
			pos[cur_len-1]++;
			while (pos[cur_len-1] >= size) begin
				cur_len--;
				if (cur_len == 0)
					return 1'b0;
				pos[cur_len-1]++;
			end
			return 1'b1;
		endfunction

		function word_res_t advance_word();
			int unsigned size;
			int unsigned lim;
			bit ok;
			logic [WORD_W-1:0] mask;
			word_res_t r;
			size = (size_reg > ALPHABET_DEPTH_DEF) ? ALPHABET_DEPTH_DEF : size_reg;
			lim = (max_len_reg == 0) ? 1 : ((max_len_reg > MAX_LEN_DEF) ? MAX_LEN_DEF : max_len_reg);
			r = '0;
			if (found || exhausted) begin
				ok = 1'b0;
			end else if (!started) begin
				started = 1'b1;
				ok = (size != 0);
				if (ok) begin
					cur_len = 1;
					pos[0] = 0;
				end
			end else if (size == 0 || cur_len == 0) begin
				ok = 1'b0;
			end else begin
				ok = next_prefix(size, lim);
			end
			if (!ok) begin
				exhausted = exhausted || !found;
				r.done = 1'b1;
				r.count = count;
				return r;
			end
			for (int k = 0; k < cur_len; k++)
				r.word[8*k +: 8] = (pos[k] < ALPHABET_DEPTH_DEF) ? letters[pos[k]] : '0;
			count = count + 1'b1;
			if (secret_len_reg != 0 && secret_len_reg <= 8 && secret_len_reg == cur_len) begin
				mask = (secret_len_reg == 8) ? '1 : ((64'd1 << (8 * secret_len_reg)) - 1);
				r.is_match = (r.word == (secret_reg & mask));
			end
			if (r.is_match)
				found = 1'b1;
			r.len = LEN_W'(cur_len);
			r.count = count;
			return r;
		endfunction

		// result of the n-th step from here, state left untouched
		function word_res_t peek_ahead(int n);
			int unsigned pos_s [MAX_LEN_DEF];
			int unsigned len_s;
			bit st_s, fd_s, ex_s;
			logic [COUNT_W-1:0] cnt_s;
			word_res_t r;
			pos_s = pos;
			len_s = cur_len;
			st_s  = started;
			fd_s  = found;
			ex_s  = exhausted;
			cnt_s = count;
			r = '0;
			for (int i = 0; i < n; i++)
				r = advance_word();
			pos       = pos_s;
			cur_len   = len_s;
			started   = st_s;
			found     = fd_s;
			exhausted = ex_s;
			count     = cnt_s;
			return r;
		endfunction

		function void note_request(logic kind, logic [IDX_W-1:0] idx, logic [CHAR_W-1:0] ch);
			if (kind == OP_LOAD)
				letters[idx] = ch;
			else
				words_due = {words_due, advance_word()};
		endfunction

		function int pending();
			return words_due.size();
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(word_res_t got);
			word_res_t want;
			if (words_due.size() == 0) begin
				report("result with no step outstanding");
				return;
			end
			want = words_due.pop_front();
			if (got.word !== want.word)
				report($sformatf("word %h, want %h", got.word, want.word));
			if (got.len !== want.len)
				report($sformatf("word_length %0d, want %0d", got.len, want.len));
			if (got.is_match !== want.is_match)
				report($sformatf("match %b, want %b", got.is_match, want.is_match));
			if (got.done !== want.done)
				report($sformatf("done_res %b, want %b", got.done, want.done));
			if (got.count !== want.count)
				report($sformatf("word_count %0d, want %0d", got.count, want.count));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	cfg_reg_t           cfg_index;
	logic [WORD_W-1:0]  cfg_data;
	logic               item_valid;
	logic               item_ready;
	logic               op;
	logic [IDX_W-1:0]   entry_index;
	logic [CHAR_W-1:0]  entry_char;
	logic               res_valid;
	logic               res_ready;
	logic [WORD_W-1:0]  word;
	logic [LEN_W-1:0]   word_length;
	logic               match;
	logic               done_res;
	logic [COUNT_W-1:0] word_count;

	word_board    board = new();
	int           items_sent = 0;
	bit           quiet = 1'b0;
	logic [7:0]   guard = 8'h00;
	int unsigned  ready_hold = 0;
	int unsigned  stall_cycles = 0;

	brute_force_word_enumerator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.op          (op),
		.entry_index (entry_index),
		.entry_char  (entry_char),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.word        (word),
		.word_length (word_length),
		.match       (match),
		.done_res    (done_res),
		.word_count  (word_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side: checks each accepted result and holds res_ready low in random stall bursts
	always @(posedge clk) begin : result_side
		word_res_t seen;
		if (arst_n && res_valid && res_ready) begin
			seen.word     = word;
			seen.len      = word_length;
			seen.is_match = match;
			seen.done     = done_res;
			seen.count    = word_count;
			board.check_result(seen);
		end
		if (ready_hold != 0) begin
			res_ready  <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			res_ready  <= 1'b0;
			ready_hold <= $urandom_range(0, 2);
		end else begin
			res_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (res_valid && res_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// a byte that no alphabet entry holds; the secret starts with it so nothing matches
	function automatic logic [7:0] pick_guard();
		logic [7:0] g;
		bit taken;
		do begin
			g = 8'($urandom_range(1, 254));
			taken = 1'b0;
			for (int i = 0; i < ALPHABET_DEPTH_DEF; i++)
				if (board.letters[i] == g)
					taken = 1'b1;
		end while (taken);
		return g;
	endfunction

	function automatic logic [7:0] pick_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == guard);
		return c;
	endfunction

	task automatic send_item(logic kind, logic [IDX_W-1:0] idx, logic [CHAR_W-1:0] ch);
		if (items_sent >= QUIET_FROM)
			quiet = 1'b1;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		item_valid  <= 1'b1;
		op          <= kind;
		entry_index <= idx;
		entry_char  <= ch;
		do @(posedge clk); while (item_ready !== 1'b1);
		board.note_request(kind, idx, ch);
		items_sent++;
	endtask

	task automatic step_item();
		send_item(OP_STEP, IDX_W'($urandom_range(0, 63)), CHAR_W'($urandom_range(0, 255)));
	endtask

	// let every outstanding result and any load still in flight drain
	task automatic settle();
		item_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// upper data bits carry junk, the block keeps only the register width
	task automatic configure(logic [3:0] ml, logic [6:0] sz, logic [63:0] sw, logic [3:0] sl);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAX_WORD_LENGTH;
		cfg_data  <= {junk[63:4], ml};
		@(posedge clk);
		cfg_index <= REG_ALPHABET_SIZE;
		cfg_data  <= {junk[63:7], sz};
		@(posedge clk);
		cfg_index <= REG_SECRET_WORD;
		cfg_data  <= sw;
		@(posedge clk);
		cfg_index <= REG_SECRET_LENGTH;
		cfg_data  <= {junk[59:0], sl};
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(REG_MAX_WORD_LENGTH, {60'd0, ml});
		board.set_reg(REG_ALPHABET_SIZE, {57'd0, sz});
		board.set_reg(REG_SECRET_WORD, sw);
		board.set_reg(REG_SECRET_LENGTH, {60'd0, sl});
	endtask

	task automatic new_setting(logic [3:0] ml, logic [6:0] sz, logic [3:0] sl);
		logic [63:0] sw;
		guard = pick_guard();
		sw = {$urandom, $urandom};
		sw[7:0] = guard;
		configure(ml, sz, sw, sl);
	endtask

	// mixed loads and steps; stops early rather than finish or hit the secret
	task automatic run_phase(int n, int step_pct);
		word_res_t ahead;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(1, 100) <= step_pct) begin
				ahead = board.peek_ahead(1);
				if (ahead.done || ahead.is_match)
					break;
				step_item();
			end else begin
				send_item(OP_LOAD, IDX_W'($urandom_range(0, 63)), pick_char());
			end
		end
		settle();
	endtask

	initial begin
		word_res_t   ahead;
		logic [3:0]  ml;
		logic [3:0]  sl;
		logic [6:0]  sz;
		logic [63:0] sw;
		int          n;
		int          j;

		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= REG_MAX_WORD_LENGTH;
		cfg_data    <= '0;
		item_valid  <= 1'b0;
		op          <= OP_LOAD;
		entry_index <= '0;
		entry_char  <= '0;
		res_ready   <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole alphabet so no step reads an unloaded entry
		for (int i = 0; i < ALPHABET_DEPTH_DEF; i++)
			send_item(OP_LOAD, IDX_W'(i), pick_char());
		run_phase(6, 100);

		// zero length taken as one, oversized alphabet saturates, secret too long
		new_setting(4'd0, 7'd127, 4'd15);
		send_item(OP_LOAD, 6'd0, 8'hFF);
		send_item(OP_LOAD, 6'd63, 8'h00);
		run_phase(2, 100);
		new_setting(4'd8, 7'd64, 4'd8);
		run_phase(5, 100);
		new_setting(4'd15, 7'd65, 4'd0);
		run_phase(3, 100);
		// shorter maximum cuts the current prefix
		new_setting(4'd3, 7'd64, 4'd3);
		run_phase(3, 100);
		new_setting(4'd1, 7'd64, 4'd1);
		run_phase(2, 100);

		while (items_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: ml = LEN_W'($urandom_range(0, 1));
				1: ml = LEN_W'($urandom_range(9, 15));
				default: ml = LEN_W'($urandom_range(2, 8));
			endcase
			case ($urandom_range(0, 7))
				0: sz = SIZE_W'($urandom_range(65, 127));
				1: sz = SIZE_W'($urandom_range(2, 31));
				default: sz = SIZE_W'($urandom_range(32, 64));
			endcase
			sl = LEN_W'($urandom_range(0, 15));
			n = (ml <= 1) ? 3 : $urandom_range(8, 40);
			new_setting(ml, sz, sl);
			run_phase(n, 80);
		end

		// the found and exhausted flags stick, so one way to finish per run
		case ($urandom_range(0, 2))
			0: begin
				j = $urandom_range(1, 20);
				ahead = board.peek_ahead(j);
				sw = {$urandom, $urandom};
				for (int k = 0; k < ahead.len; k++)
					sw[8*k +: 8] = ahead.word[8*k +: 8];
				configure(board.max_len_reg, board.size_reg, sw, ahead.len);
				repeat (j + 4) step_item();
			end
			1: begin
				configure(LEN_W'($urandom_range(1, 3)), SIZE_W'($urandom_range(1, 3)), '1,
					4'd8);
				do begin
					ahead = board.peek_ahead(1);
					step_item();
				end while (!ahead.done);
				repeat (3) step_item();
			end
			default: begin
				new_setting(LEN_W'($urandom_range(0, 15)), 7'd0, LEN_W'($urandom_range(0, 15)));
				repeat (4) step_item();
			end
		endcase
		settle();

		if (board.errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
